// ----- sv/bzc_pkg.sv -----
// Package for the back-EMF zero-crossing detector.
// Holds the shared widths, reset values, sign codes and the filter control struct.
// No dependencies.
package bzc_pkg;

    // Default widths of the ADC codes and of the wrapping tallies.
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = 16;

    // Number of motor phases in one scan, and the divisor of the neutral.
    localparam int PHASES = 3;

    // Width and reset value of the confirm count register and the run counters.
    localparam int             RUN_BITS      = 4;
    localparam logic [RUN_BITS-1:0] CONFIRM_RESET = 4'd3;

    // Confirmed and candidate sign codes.
    typedef enum logic [1:0] {
        LEVEL_NONE = 2'd0,
        LEVEL_POS  = 2'd1,
        LEVEL_NEG  = 2'd2
    } t_level;

    // Control handed from the top level to each phase filter.
    typedef struct packed {
        logic update;    // An item moves into the result register this cycle.
        logic negative;  // The phase difference of that item is below zero.
    } t_filt_ctrl;

endpackage

// ----- sv/bzc_phase_filter.sv -----
// Sign filter and crossing counter for one motor phase.
// Depends on bzc_pkg for the sign codes, the run width and the control struct.
module bzc_phase_filter #(
    parameter int COUNT_BITS = bzc_pkg::COUNT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bzc_pkg::t_filt_ctrl           i_ctrl,
    input  logic [bzc_pkg::RUN_BITS-1:0]  i_confirm_count,
    output bzc_pkg::t_level               o_level,
    output logic [COUNT_BITS-1:0]         o_crossings
);

    bzc_pkg::t_level               r_candidate;
    bzc_pkg::t_level               n_candidate;
    bzc_pkg::t_level               r_confirmed;
    bzc_pkg::t_level               n_confirmed;
    logic [bzc_pkg::RUN_BITS-1:0]  r_run;
    logic [bzc_pkg::RUN_BITS-1:0]  n_run;
    logic [COUNT_BITS-1:0]         r_tally;
    logic [COUNT_BITS-1:0]         n_tally;
    bzc_pkg::t_level               w_sign;

    // The sign of this item: zero counts as positive.
    assign w_sign = i_ctrl.negative ? bzc_pkg::LEVEL_NEG : bzc_pkg::LEVEL_POS;

    // Run tracking, then confirmation once the run reaches the confirm count.
    always_comb begin
        n_candidate = r_candidate;
        n_confirmed = r_confirmed;
        n_run       = r_run;
        n_tally     = r_tally;
        if (i_ctrl.update) begin
            if (w_sign != r_candidate) begin
                n_candidate = w_sign;
                n_run       = bzc_pkg::RUN_BITS'(1);
            end else if (r_run < i_confirm_count) begin
                n_run = r_run + bzc_pkg::RUN_BITS'(1);
            end
            if (n_run == i_confirm_count && r_confirmed != w_sign) begin
                n_confirmed = w_sign;
                n_tally     = r_tally + COUNT_BITS'(1);
            end
        end
    end

    // Filter state; the confirmed sign and tally are the result values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_candidate <= bzc_pkg::LEVEL_NONE;
            r_confirmed <= bzc_pkg::LEVEL_NONE;
            r_run       <= '0;
            r_tally     <= '0;
        end else begin
            r_candidate <= n_candidate;
            r_confirmed <= n_confirmed;
            r_run       <= n_run;
            r_tally     <= n_tally;
        end
    end

    assign o_level     = r_confirmed;
    assign o_crossings = r_tally;

endmodule

// ----- sv/bemf_zero_cross_detector.sv -----
// Top level of the back-EMF zero-crossing detector.
// Depends on bzc_pkg and instantiates bzc_phase_filter once per phase.

// The block takes one three-phase ADC scan per item and can accept a new
// scan in every clock cycle while the output side is not stalled. A scan
// first lands in an input register; from there one pass of logic forms the
// virtual neutral (the floor of the sum over three, done as a multiply by a
// fixed reciprocal), the three phase differences and the per-phase sign
// filter updates, and the result register takes the item once it is free.
// Throughput is one item per cycle as long as the output side is not
// stalled. While the result waits, one more scan is held in the input
// register before the input side stalls. The confirm count may be written
// only while no item is in flight; its reset value is three.
module bemf_zero_cross_detector #(
    parameter int SAMPLE_BITS = bzc_pkg::SAMPLE_BITS,
    parameter int COUNT_BITS  = bzc_pkg::COUNT_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [bzc_pkg::RUN_BITS-1:0]  i_cfg_wdata,
    // Scan input channel.
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [SAMPLE_BITS-1:0]        i_sample_a,
    input  logic [SAMPLE_BITS-1:0]        i_sample_b,
    input  logic [SAMPLE_BITS-1:0]        i_sample_c,
    // Result channel.
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [SAMPLE_BITS-1:0]        o_neutral,
    output logic signed [SAMPLE_BITS:0]   o_diff_a,
    output logic signed [SAMPLE_BITS:0]   o_diff_b,
    output logic signed [SAMPLE_BITS:0]   o_diff_c,
    output logic [COUNT_BITS-1:0]         o_crossings_a,
    output logic [COUNT_BITS-1:0]         o_crossings_b,
    output logic [COUNT_BITS-1:0]         o_crossings_c,
    output logic [1:0]                    o_level_a,
    output logic [1:0]                    o_level_b,
    output logic [1:0]                    o_level_c,
    output logic [COUNT_BITS-1:0]         o_scans_seen
);

    // Sum width, and the reciprocal of three used for the neutral.
    localparam int SumBits  = SAMPLE_BITS + 2;
    localparam int DivShift = SumBits + 2;
    localparam int ProdBits = SumBits + DivShift;
    localparam logic [DivShift-1:0] DivMul =
        DivShift'(((64'd1 << DivShift) + 64'd2) / bzc_pkg::PHASES);

    logic [bzc_pkg::RUN_BITS-1:0]  r_confirm_count;

    logic                          r_s1_valid;
    logic [SAMPLE_BITS-1:0]        r_samp [bzc_pkg::PHASES];
    logic                          r_out_valid;
    logic [SAMPLE_BITS-1:0]        r_neutral;
    logic [SAMPLE_BITS:0]          r_diff [bzc_pkg::PHASES];
    logic [COUNT_BITS-1:0]         r_scan;

    logic                          w_out_free;
    logic                          w_s1_move;
    logic                          w_in_accept;
    logic [SumBits-1:0]            w_sum;
    logic [ProdBits-1:0]           w_prod;
    logic [SAMPLE_BITS-1:0]        w_neutral;
    logic [SumBits-1:0]            w_rem;
    logic [SAMPLE_BITS:0]          w_diff [bzc_pkg::PHASES];
    bzc_pkg::t_filt_ctrl           w_ctrl [bzc_pkg::PHASES];
    bzc_pkg::t_level               w_level [bzc_pkg::PHASES];
    logic [COUNT_BITS-1:0]         w_cross [bzc_pkg::PHASES];

    // Confirm count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_confirm_count <= bzc_pkg::CONFIRM_RESET;
        end else if (i_cfg_we) begin
            r_confirm_count <= i_cfg_wdata;
        end
    end

    // Pipeline flow: the result register frees when empty or taken.
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_s1_move   = r_s1_valid && w_out_free;
    assign o_in_stall  = r_s1_valid && !w_out_free;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // Input register stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_samp[0] <= i_sample_a;
            r_samp[1] <= i_sample_b;
            r_samp[2] <= i_sample_c;
        end
    end

    // Virtual neutral: floor of the sum over three by reciprocal multiply.
    assign w_sum  = SumBits'(r_samp[0]) + SumBits'(r_samp[1]) + SumBits'(r_samp[2]);
    assign w_prod = ProdBits'(w_sum) * ProdBits'(DivMul);
    assign w_neutral = w_prod[DivShift +: SAMPLE_BITS];
    assign w_rem = w_sum - SumBits'({w_neutral, 1'b0}) - SumBits'(w_neutral);

    // Phase differences and the control for each sign filter.
    for (genvar p = 0; p < bzc_pkg::PHASES; p++) begin : g_phase
        assign w_diff[p] = {1'b0, r_samp[p]} - {1'b0, w_neutral};
        assign w_ctrl[p] = '{update: w_s1_move, negative: w_diff[p][SAMPLE_BITS]};

        bzc_phase_filter #(
            .COUNT_BITS (COUNT_BITS)
        ) u_filter (
            .i_clk           (i_clk),
            .i_rst_n         (i_rst_n),
            .i_ctrl          (w_ctrl[p]),
            .i_confirm_count (r_confirm_count),
            .o_level         (w_level[p]),
            .o_crossings     (w_cross[p])
        );
    end

    // Result register stage and the scan tally.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_scan      <= '0;
        end else begin
            if (w_s1_move) begin
                r_out_valid <= 1'b1;
                r_scan      <= r_scan + COUNT_BITS'(1);
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move) begin
            r_neutral <= w_neutral;
            r_diff[0] <= w_diff[0];
            r_diff[1] <= w_diff[1];
            r_diff[2] <= w_diff[2];
        end
    end

    // Outputs; levels and crossings are the filter state, the scan tally is the top-level tally.
    assign o_out_valid   = r_out_valid;
    assign o_neutral     = r_neutral;
    assign o_diff_a      = r_diff[0];
    assign o_diff_b      = r_diff[1];
    assign o_diff_c      = r_diff[2];
    assign o_crossings_a = w_cross[0];
    assign o_crossings_b = w_cross[1];
    assign o_crossings_c = w_cross[2];
    assign o_level_a     = w_level[0];
    assign o_level_b     = w_level[1];
    assign o_level_c     = w_level[2];
    assign o_scans_seen  = r_scan;

    // The neutral is the exact floor of the sum over three.
    a_neutral_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_move |-> (w_rem < SumBits'(bzc_pkg::PHASES)))
        else $error("neutral is not the floor of the sum over three");

    // A held scan stays in the input register until the result side frees.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_move) |=> (r_s1_valid && $stable(r_samp[0])
            && $stable(r_samp[1]) && $stable(r_samp[2])))
        else $error("held scan was lost or changed");

    // The scan tally steps exactly when an item enters the result register.
    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_move |=> (r_scan == $past(r_scan) + COUNT_BITS'(1)))
        else $error("scan tally did not step with the item");

    a_scan_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_move |=> $stable(r_scan))
        else $error("scan tally changed without an item");

    // A change of the confirmed sign on phase A always counts one crossing.
    a_cross_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_level_a != $past(o_level_a)) |->
            (o_crossings_a == $past(o_crossings_a) + COUNT_BITS'(1)))
        else $error("phase A sign changed without a crossing count");

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for the back-EMF zero-crossing detector.
// Drives three-phase scans, predicts neutral, differences, sign filters and tallies,
// and checks every result. Depends on bzc_pkg and bemf_zero_cross_detector.
module tb;

    localparam int SB         = bzc_pkg::SAMPLE_BITS;
    localparam int CB         = bzc_pkg::COUNT_BITS;
    localparam int RUN_BITS   = bzc_pkg::RUN_BITS;
    localparam int IDLE_LIMIT = 2000;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_LEN  = 190;
    localparam int ALT_SCANS  = 16;

    typedef logic [2:0][SB-1:0] t_scan;

    typedef struct packed {
        logic [SB-1:0]        neutral;
        logic [2:0][SB:0]     diff;
        logic [2:0][CB-1:0]   crossings;
        logic [2:0][1:0]      level;
        logic [CB-1:0]        scans;
    } t_scan_result;

    // Clock, reset and block ports.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [RUN_BITS-1:0] cfg_wdata = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [SB-1:0] sample_a = '0;
    logic [SB-1:0] sample_b = '0;
    logic [SB-1:0] sample_c = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic [SB-1:0] neutral;
    logic signed [SB:0] diff_a, diff_b, diff_c;
    logic [CB-1:0] crossings_a, crossings_b, crossings_c;
    logic [1:0] level_a, level_b, level_c;
    logic [CB-1:0] scans_seen;

    logic [2:0][SB:0]   got_diff;
    logic [2:0][CB-1:0] got_crossings;
    logic [2:0][1:0]    got_level;

    assign got_diff      = {diff_c, diff_b, diff_a};
    assign got_crossings = {crossings_c, crossings_b, crossings_a};
    assign got_level     = {level_c, level_b, level_a};

    // Stimulus and expectation stores.
    t_scan        scan_queue[$];
    t_scan_result pending_results[$];
    t_scan        next_scan;
    t_scan_result want;
    logic         scan_taken = 1'b0;
    int           send_idle_pct = 0;
    int           stall_pct = 0;
    int           errors = 0;
    int           scans_sent = 0;
    int           results_checked = 0;
    int           idle_cycles = 0;
    string        phase_tags[3] = '{"a", "b", "c"};

    // Predictor state: sign filters, tallies and the confirm count.
    logic [RUN_BITS-1:0] confirm_setting = bzc_pkg::CONFIRM_RESET;
    bzc_pkg::t_level     cand_level[3] = '{bzc_pkg::LEVEL_NONE, bzc_pkg::LEVEL_NONE,
                                           bzc_pkg::LEVEL_NONE};
    bzc_pkg::t_level     conf_level[3] = '{bzc_pkg::LEVEL_NONE, bzc_pkg::LEVEL_NONE,
                                           bzc_pkg::LEVEL_NONE};
    logic [RUN_BITS-1:0] run_len[3] = '{default: '0};
    logic [CB-1:0]       crossing_count[3] = '{default: '0};
    logic [CB-1:0]       scan_count = '0;

    bemf_zero_cross_detector dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_sample_a    (sample_a),
        .i_sample_b    (sample_b),
        .i_sample_c    (sample_c),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_neutral     (neutral),
        .o_diff_a      (diff_a),
        .o_diff_b      (diff_b),
        .o_diff_c      (diff_c),
        .o_crossings_a (crossings_a),
        .o_crossings_b (crossings_b),
        .o_crossings_c (crossings_c),
        .o_level_a     (level_a),
        .o_level_b     (level_b),
        .o_level_c     (level_c),
        .o_scans_seen  (scans_seen)
    );

    // Clock generation.
    initial begin
        forever #10 clk = ~clk;
    end

    // Updates the filter state with one scan and returns the result it shows.
    function automatic t_scan_result predict_scan(input t_scan scan);
        t_scan_result r;
        int nval;
        int dval;
        bzc_pkg::t_level sign;
        nval = (int'(scan[0]) + int'(scan[1]) + int'(scan[2])) / 3;
        r.neutral = SB'(nval);
        for (int p = 0; p < 3; p++) begin
            dval = int'(scan[p]) - nval;
            r.diff[p] = (SB + 1)'(dval);
            sign = (dval < 0) ? bzc_pkg::LEVEL_NEG : bzc_pkg::LEVEL_POS;
            if (sign != cand_level[p]) begin
                cand_level[p] = sign;
                run_len[p] = RUN_BITS'(1);
            end else if (run_len[p] < confirm_setting) begin
                run_len[p] = run_len[p] + 1'b1;
            end
            if (run_len[p] == confirm_setting && conf_level[p] != sign) begin
                conf_level[p] = sign;
                crossing_count[p] = crossing_count[p] + 1'b1;
            end
            r.crossings[p] = crossing_count[p];
            r.level[p] = conf_level[p];
        end
        scan_count = scan_count + 1'b1;
        r.scans = scan_count;
        return r;
    endfunction

    task automatic check_field(input string name, input int expv, input int actv);
        if (expv != actv) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, expv, actv);
        end
    endtask

    task automatic push_scan(input int a, input int b, input int c);
        t_scan s;
        s[0] = SB'(a);
        s[1] = SB'(b);
        s[2] = SB'(c);
        scan_queue.push_back(s);
    endtask

    // Motor-like waveforms: three triangles 120 degrees apart with noise, plus spikes.
    task automatic queue_waveform(input int count);
        int center;
        int amp;
        int step_deg;
        int noise;
        int theta;
        int t;
        int ramp;
        int v[3];
        center = 2048;
        amp = 1000;
        step_deg = 5;
        noise = 10;
        theta = 0;
        for (int n = 0; n < count; n++) begin
            if (n == 0 || $urandom_range(99) < 5) begin
                center = $urandom_range(300, 3800);
                amp = $urandom_range(20, 2000);
                step_deg = $urandom_range(1, 12);
                noise = $urandom_range(0, 40);
                theta = $urandom_range(0, 359);
            end
            if ($urandom_range(99) < 12) begin
                push_scan($urandom_range(4095), $urandom_range(4095), $urandom_range(4095));
            end else if ($urandom_range(99) < 3) begin
                v[0] = $urandom_range(4095);
                push_scan(v[0], v[0], v[0]);
            end else begin
                for (int p = 0; p < 3; p++) begin
                    t = (theta + p * 240) % 360;
                    ramp = (t < 180) ? t - 90 : 270 - t;
                    v[p] = center + amp * ramp / 90 + int'($urandom_range(0, 2 * noise)) - noise;
                    if (v[p] < 0) v[p] = 0;
                    if (v[p] > 4095) v[p] = 4095;
                end
                push_scan(v[0], v[1], v[2]);
                theta = (theta + step_deg) % 360;
            end
        end
    endtask

    // Waits until every scan is sent and every result has been checked.
    task automatic wait_drained();
        while (scan_queue.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_confirm(input logic [RUN_BITS-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        confirm_setting = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Scan driver: offers the next pending item once the previous one is taken.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || scan_taken)) begin
            if (scan_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_scan = scan_queue.pop_front();
                in_valid <= 1'b1;
                sample_a <= next_scan[0];
                sample_b <= next_scan[1];
                sample_c <= next_scan[2];
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result side back-pressure.
    always @(negedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // Accepted scans go through the predictor.
    always @(posedge clk) begin
        scan_taken <= rst_n && in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall) begin
            pending_results.push_back(predict_scan({sample_c, sample_b, sample_a}));
            scans_sent++;
        end
    end

    // Result monitor: compares each accepted result with the oldest expectation.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with no scan waiting, expected none, got neutral %0d",
                         $time, neutral);
            end else begin
                want = pending_results.pop_front();
                check_field("neutral", want.neutral, neutral);
                check_field("scans_seen", want.scans, scans_seen);
                for (int p = 0; p < 3; p++) begin
                    check_field({"diff_", phase_tags[p]}, $signed(want.diff[p]),
                                $signed(got_diff[p]));
                    check_field({"crossings_", phase_tags[p]}, want.crossings[p],
                                got_crossings[p]);
                    check_field({"level_", phase_tags[p]}, want.level[p], got_level[p]);
                end
                results_checked++;
            end
        end
    end

    // Watchdog on cycles in which neither channel moves an item.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout after %0d cycles with no item moving", idle_cycles);
            $display("bemf_zero_cross_detector test failed");
            $finish;
        end
    end

    // Test sequence: reset, directed scans, random phases, then a sign flip run.
    initial begin
        logic [RUN_BITS-1:0] confirm_plan[NUM_PHASES];
        confirm_plan = '{4'd3, 4'd1, 4'd15, 4'd0, 4'd2, 4'd8, 4'd5, 4'd15};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed scans under the reset confirm count.
        push_scan(0, 0, 0);
        push_scan(4095, 4095, 4095);
        push_scan(4095, 0, 0);
        push_scan(4095, 0, 0);
        push_scan(4095, 0, 0);
        push_scan(0, 4095, 4095);
        push_scan(0, 4095, 4095);
        push_scan(0, 4095, 4095);
        push_scan(0, 4095, 0);
        push_scan(0, 0, 4095);
        push_scan(4095, 4095, 0);
        push_scan(1, 1, 0);
        push_scan(0, 0, 1);
        push_scan(2, 1, 1);
        push_scan(2730, 2731, 2731);
        push_scan(4094, 4095, 4095);
        push_scan(0, 0, 2);
        push_scan(0, 0, 2);
        push_scan(0, 0, 2);
        push_scan(2048, 2047, 2049);
        wait_drained();

        // Random phases, each with its own confirm count and idling pattern.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                write_confirm((ph == 6) ? RUN_BITS'($urandom_range(1, 15)) : confirm_plan[ph]);
            end
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 68; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 68; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            queue_waveform(PHASE_LEN);
            wait_drained();
        end

        // Alternating signs with a confirm count of one cross every phase on every scan after the first.
        send_idle_pct = 0;
        stall_pct = 0;
        write_confirm(4'd1);
        for (int n = 0; n < ALT_SCANS; n++) begin
            if (n % 2 == 0) begin
                push_scan($urandom_range(3300, 4095), $urandom_range(0, 800),
                          $urandom_range(0, 800));
            end else begin
                push_scan($urandom_range(0, 800), $urandom_range(3300, 4095),
                          $urandom_range(3300, 4095));
            end
        end
        wait_drained();
        repeat (8) @(posedge clk);

        $display("Checked %0d results from %0d scans over %0d confirm count settings,",
                 results_checked, scans_sent, NUM_PHASES + 1);
        $display("with sender gaps, receiver stalls and a crossing on every scan.");
        if (errors == 0) begin
            $display("bemf_zero_cross_detector test passed");
        end else begin
            $display("bemf_zero_cross_detector test failed");
        end
        $finish;
    end

endmodule
